/* design/ppvp_pkg.sv */
package ppvp_pkg;

  // Field widths fixed by the interface
  localparam int TIME_BITS      = 63;
  localparam int TOKEN_FIELD    = 32;
  localparam int TIMEOUT_BITS   = 32;
  localparam int MODE_BITS      = 3;
  localparam int ACTION_BITS    = 2;
  localparam int OUTCOME_BITS   = 3;

  // Defaults
  localparam int TOKEN_BITS_DEFAULT = 32;
  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET = TIMEOUT_BITS'(3000);

  // Event codes
  localparam logic [MODE_BITS-1:0] MODE_START   = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_ADVANCE = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_V2_REPLY = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_V1_REPLY = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_CANCEL  = 3'd4;

  // Action codes
  localparam logic [ACTION_BITS-1:0] ACT_NONE = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_V2   = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_V1   = 2'd2;
  localparam logic [ACTION_BITS-1:0] ACT_DONE = 2'd3;

  // Outcome codes
  localparam logic [OUTCOME_BITS-1:0] OUT_NONE   = 3'd0;
  localparam logic [OUTCOME_BITS-1:0] OUT_LOCAL  = 3'd1;
  localparam logic [OUTCOME_BITS-1:0] OUT_NORESP = 3'd2;
  localparam logic [OUTCOME_BITS-1:0] OUT_AUTH   = 3'd3;
  localparam logic [OUTCOME_BITS-1:0] OUT_V2     = 3'd4;
  localparam logic [OUTCOME_BITS-1:0] OUT_V1     = 3'd5;

  // Probe phase of the session
  typedef enum logic [1:0] {
    PH_NONE = 2'd0,
    PH_V2   = 2'd1,
    PH_V1   = 2'd2
  } phase_t;

  typedef struct packed {
    logic [MODE_BITS-1:0]   mode;
    logic [TIME_BITS-1:0]   now_ms;
    logic                   local_config_complete;
    logic [TOKEN_FIELD-1:0] saved_endpoint;
    logic [TOKEN_FIELD-1:0] event_token;
    logic [TOKEN_FIELD-1:0] source_endpoint;
    logic                   authenticated;
    logic                   reply_accepted;
  } req_t;

  typedef struct packed {
    logic [ACTION_BITS-1:0]  action;
    logic [TOKEN_FIELD-1:0]  probe_event;
    logic [OUTCOME_BITS-1:0] outcome;
    logic [TOKEN_FIELD-1:0]  observed_endpoint;
    logic                    confirm_required;
    logic                    endpoint_changed;
    logic                    session_active;
  } res_t;

endpackage

/* design/ppvp_in_stage.sv */
module ppvp_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  ppvp_pkg::req_t  req,
  input  logic            advance,
  output logic            valid,
  output ppvp_pkg::req_t  item
);

  logic accept;
  logic valid_next;

  // Hold the request while the stage downstream is full
  assign req_stall = valid & ~advance;
  assign accept    = req_valid & ~req_stall;

  always_comb begin
    if (accept) begin
      valid_next = 1'b1;
    end else if (advance) begin
      valid_next = 1'b0;
    end else begin
      valid_next = valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Request payload
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
    end
  end

endmodule

/* design/ppvp_core.sv */
module ppvp_core #(
  parameter int TOKEN_BITS = ppvp_pkg::TOKEN_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 fire,
  input  ppvp_pkg::req_t                       item,
  input  logic                                 cfg_we,
  input  logic [ppvp_pkg::TIMEOUT_BITS-1:0]    cfg_wdata,
  output ppvp_pkg::res_t                       result
);

  // Stored token width: tokens are masked to TOKEN_BITS within the 32-bit field
  localparam int TW = (TOKEN_BITS < ppvp_pkg::TOKEN_FIELD) ? TOKEN_BITS
                                                           : ppvp_pkg::TOKEN_FIELD;

  logic [ppvp_pkg::TIMEOUT_BITS-1:0] probe_timeout_ms;
  logic                              active;
  ppvp_pkg::phase_t                  phase;
  logic [ppvp_pkg::TIME_BITS-1:0]    deadline_ms;
  logic [TW-1:0]                     pending_token;
  logic [TW-1:0]                     stored_endpoint;
  logic                              fallback_sent;

  logic                              active_next;
  ppvp_pkg::phase_t                  phase_next;
  logic [ppvp_pkg::TIME_BITS-1:0]    deadline_ms_next;
  logic [TW-1:0]                     pending_token_next;
  logic [TW-1:0]                     stored_endpoint_next;
  logic                              fallback_sent_next;

  logic [TW-1:0]                     tok;
  logic [TW-1:0]                     saved;
  logic [TW-1:0]                     src;
  logic [ppvp_pkg::TIME_BITS:0]      deadline_sum;
  logic [ppvp_pkg::TIME_BITS-1:0]    deadline_new;
  logic                              start_ok;
  logic                              adv_due;
  logic                              adv_fallback;
  logic                              v2_hit;
  logic                              v1_hit;
  logic                              differs;

  assign tok   = item.event_token[TW-1:0];
  assign saved = item.saved_endpoint[TW-1:0];
  assign src   = item.source_endpoint[TW-1:0];

  // Saturating deadline: now plus timeout, clamped to the largest time
  assign deadline_sum = {1'b0, item.now_ms}
                      + (ppvp_pkg::TIME_BITS + 1)'(probe_timeout_ms);
  assign deadline_new = deadline_sum[ppvp_pkg::TIME_BITS] ? '1
                      : deadline_sum[ppvp_pkg::TIME_BITS-1:0];

  // Event conditions
  assign start_ok     = item.local_config_complete & (tok != '0);
  assign adv_due      = active & (item.now_ms >= deadline_ms);
  assign adv_fallback = adv_due & (phase == ppvp_pkg::PH_V2) & ~fallback_sent
                      & (tok != '0);
  assign v2_hit       = active & (phase == ppvp_pkg::PH_V2)
                      & (item.now_ms <= deadline_ms) & (tok == pending_token);
  assign v1_hit       = active & (phase == ppvp_pkg::PH_V1)
                      & (item.now_ms <= deadline_ms) & (tok == pending_token)
                      & item.reply_accepted;
  assign differs      = stored_endpoint != src;

  // Next state
  always_comb begin
    active_next          = active;
    phase_next           = phase;
    deadline_ms_next     = deadline_ms;
    pending_token_next   = pending_token;
    stored_endpoint_next = stored_endpoint;
    fallback_sent_next   = fallback_sent;
    case (item.mode)
      ppvp_pkg::MODE_START: begin
        fallback_sent_next = 1'b0;
        if (start_ok) begin
          active_next          = 1'b1;
          phase_next           = ppvp_pkg::PH_V2;
          deadline_ms_next     = deadline_new;
          pending_token_next   = tok;
          stored_endpoint_next = saved;
        end else begin
          active_next          = 1'b0;
          phase_next           = ppvp_pkg::PH_NONE;
          deadline_ms_next     = '0;
          pending_token_next   = '0;
          stored_endpoint_next = '0;
        end
      end
      ppvp_pkg::MODE_ADVANCE: begin
        if (adv_fallback) begin
          phase_next         = ppvp_pkg::PH_V1;
          fallback_sent_next = 1'b1;
          pending_token_next = tok;
          deadline_ms_next   = deadline_new;
        end else if (adv_due) begin
          active_next        = 1'b0;
          phase_next         = ppvp_pkg::PH_NONE;
          pending_token_next = '0;
        end
      end
      ppvp_pkg::MODE_V2_REPLY: begin
        if (v2_hit) begin
          active_next        = 1'b0;
          phase_next         = ppvp_pkg::PH_NONE;
          pending_token_next = '0;
        end
      end
      ppvp_pkg::MODE_V1_REPLY: begin
        if (v1_hit) begin
          active_next        = 1'b0;
          phase_next         = ppvp_pkg::PH_NONE;
          pending_token_next = '0;
        end
      end
      ppvp_pkg::MODE_CANCEL: begin
        active_next          = 1'b0;
        phase_next           = ppvp_pkg::PH_NONE;
        deadline_ms_next     = '0;
        pending_token_next   = '0;
        stored_endpoint_next = '0;
        fallback_sent_next   = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // Result for the current request
  always_comb begin
    result                  = '0;
    result.action           = ppvp_pkg::ACT_NONE;
    result.outcome          = ppvp_pkg::OUT_NONE;
    result.session_active   = active_next;
    case (item.mode)
      ppvp_pkg::MODE_START: begin
        if (start_ok) begin
          result.action               = ppvp_pkg::ACT_V2;
          result.probe_event[TW-1:0]  = tok;
        end else begin
          result.action  = ppvp_pkg::ACT_DONE;
          result.outcome = ppvp_pkg::OUT_LOCAL;
        end
      end
      ppvp_pkg::MODE_ADVANCE: begin
        if (adv_fallback) begin
          result.action              = ppvp_pkg::ACT_V1;
          result.probe_event[TW-1:0] = tok;
        end else if (adv_due) begin
          result.action  = ppvp_pkg::ACT_DONE;
          result.outcome = ppvp_pkg::OUT_NORESP;
        end
      end
      ppvp_pkg::MODE_V2_REPLY: begin
        if (v2_hit) begin
          result.action = ppvp_pkg::ACT_DONE;
          if (!item.authenticated) begin
            result.outcome = ppvp_pkg::OUT_AUTH;
          end else begin
            result.outcome                   = ppvp_pkg::OUT_V2;
            result.observed_endpoint[TW-1:0] = src;
            result.confirm_required          = (stored_endpoint == '0) | differs;
            result.endpoint_changed          = (stored_endpoint != '0) & differs;
          end
        end
      end
      ppvp_pkg::MODE_V1_REPLY: begin
        if (v1_hit) begin
          result.action  = ppvp_pkg::ACT_DONE;
          result.outcome = ppvp_pkg::OUT_V1;
        end
      end
      default: begin
      end
    endcase
  end

  // Timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_timeout_ms <= ppvp_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      probe_timeout_ms <= cfg_wdata;
    end
  end

  // Session state, updated once per request
  always_ff @(posedge clk) begin
    if (rst) begin
      active          <= 1'b0;
      phase           <= ppvp_pkg::PH_NONE;
      deadline_ms     <= '0;
      pending_token   <= '0;
      stored_endpoint <= '0;
      fallback_sent   <= 1'b0;
    end else if (fire) begin
      active          <= active_next;
      phase           <= phase_next;
      deadline_ms     <= deadline_ms_next;
      pending_token   <= pending_token_next;
      stored_endpoint <= stored_endpoint_next;
      fallback_sent   <= fallback_sent_next;
    end
  end

`ifndef SYNTHESIS
  // A session is active exactly when a probe phase is set
  a_active_phase: assert property (@(posedge clk) disable iff (rst)
    active == (phase != ppvp_pkg::PH_NONE))
    else $error("active flag and probe phase disagree");

  // An outstanding probe always has a token
  a_active_token: assert property (@(posedge clk) disable iff (rst)
    active |-> (pending_token != '0))
    else $error("active session with empty pending token");

  // While active, the v1 phase and the fallback mark go together
  a_fallback_phase: assert property (@(posedge clk) disable iff (rst)
    active |-> (fallback_sent == (phase == ppvp_pkg::PH_V1)))
    else $error("fallback mark does not match probe phase");
`endif

endmodule

/* design/peer_protocol_version_probe.sv */
// Peer protocol version probe. Each request is one event (start, time advance,
// v2 reply, v1 reply, cancel) and yields exactly one result, in order. A
// request is registered on entry in the input stage, evaluated against the
// session state and the result is registered on exit in the result register;
// a new request is taken every cycle while the result is not stalled. The rate
// is set by the update of the session state (one 64-bit deadline add and the
// 63-bit deadline compares). Write probe_timeout_ms only while no
// request is in flight.
module peer_protocol_version_probe #(
  parameter int TOKEN_BITS = ppvp_pkg::TOKEN_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  ppvp_pkg::req_t                    req,
  output logic                              res_valid,
  input  logic                              res_stall,
  output ppvp_pkg::res_t                    res,
  input  logic                              cfg_we,
  input  logic [ppvp_pkg::TIMEOUT_BITS-1:0] cfg_wdata
);

  logic           advance;
  logic           s1_valid;
  ppvp_pkg::req_t s1_item;
  logic           fire;
  ppvp_pkg::res_t result;
  logic           res_valid_next;

  // Result register frees up when empty or being taken
  assign advance = ~res_valid | ~res_stall;
  assign fire    = s1_valid & advance;

  ppvp_in_stage u_in_stage (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .advance   (advance),
    .valid     (s1_valid),
    .item      (s1_item)
  );

  ppvp_core #(
    .TOKEN_BITS (TOKEN_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .item      (s1_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .result    (result)
  );

  // Result register
  assign res_valid_next = fire | (res_valid & res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= result;
    end
  end

`ifndef SYNTHESIS
  // Completion carries an outcome, and only completion does
  a_done_outcome: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res.action == ppvp_pkg::ACT_DONE) ==
                   (res.outcome != ppvp_pkg::OUT_NONE)))
    else $error("action and outcome disagree");

  // A probe token is reported only with a probe action
  a_probe_token: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.probe_event != '0) |->
      (res.action == ppvp_pkg::ACT_V2 || res.action == ppvp_pkg::ACT_V1))
    else $error("probe token without probe action");
`endif

endmodule
